// ===== hdl/sync_header_frame_parser_crc32_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync header frame parser
// Shared wrappers for the concurrent checks in the parser top level.
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_FRAME_PARSER_CRC32_TOP_ASSERT_SVH
`define SYNC_HEADER_FRAME_PARSER_CRC32_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/shfp_pkg.sv =====
// ----------------------------------------------------------------------------
// shfp_pkg
// Constants, types and the CRC-32 byte update shared by the frame parser.
// ----------------------------------------------------------------------------
package shfp_pkg;

    localparam logic [7:0]  SYNC1          = 8'hAA;
    localparam logic [7:0]  SYNC2          = 8'h44;
    localparam logic [7:0]  SYNC3          = 8'h18;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [15:0] CRC_BYTES      = 16'd4;
    localparam logic [4:0]  HEADER_BYTES   = 5'd20;
    localparam logic [4:0]  LEN_LO_OFS     = 5'd12;
    localparam logic [4:0]  LEN_HI_OFS     = 5'd13;

    typedef enum logic [2:0] {
        ROLE_DISCARD = 3'd0,
        ROLE_SYNC    = 3'd1,
        ROLE_HEADER  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_CRC     = 3'd4
    } role_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic        crc_good;
        logic        frame_end;
        logic        frame_start;
        role_t       byte_role;
        logic [7:0]  byte_echo;
    } shfp_result_t;

    // Reflected CRC-32, one byte; unrolls into an XOR tree.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Register value after the first sync byte of a frame.
    localparam logic [31:0] CRC_AFTER_SYNC1 = crc_byte(CRC_INIT, SYNC1);

endpackage

// ===== hdl/sync_header_frame_parser_crc32_top.sv =====
// ----------------------------------------------------------------------------
// sync_header_frame_parser_crc32_top
// Sync-word framed byte parser with a reflected CRC-32 frame check.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the s_axis channel, one byte per beat. Every
// input beat produces exactly one output beat on the m_axis channel that
// echoes the byte together with its role in the frame (discarded, sync,
// header, payload or CRC), a frame-start flag on an accepted first sync byte,
// tlast on the last CRC byte, the CRC verdict and the payload length taken
// from the header. The cfg_wr_en / cfg_wr_data port sets ignore_crc; write it
// only while no beat is in flight.
// A byte is captured in the input register, and the parser then updates its
// state and loads the result register. Throughput is one byte per cycle
// while m_axis_tready is high, set by the byte-wide CRC update and frame
// state machine in the parser.
// A new byte is accepted while a result waits: the input register and the
// result register form a two-entry pipeline, so when the receiver stalls
// one more byte is taken before s_axis_tready falls. Nothing is dropped.
// Synchronous reset (aresetn low) empties both registers, returns the parser
// to the sync hunt with the CRC at all ones and clears ignore_crc.
// ----------------------------------------------------------------------------
`include "sync_header_frame_parser_crc32_top_assert.svh"

module sync_header_frame_parser_crc32_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: ignore_crc.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_echo, [23:8] payload_length
    output logic [4:0]  m_axis_tuser,   // [2:0] byte_role, [3] frame_start, [4] crc_good
    output logic        m_axis_tlast    // frame_end
);
    import shfp_pkg::*;

    logic         ignore_crc_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         in_accept;
    shfp_result_t result;

    // The parser consumes the held byte whenever the result register is free
    // or is being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_crc_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ignore_crc_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The byte itself needs no reset; it is qualified by in_valid_reg.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    shfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .ignore_crc (ignore_crc_reg),
        .rx_byte    (in_byte_reg),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result.payload_length, result.byte_echo};
    assign m_axis_tuser  = {result.crc_good, result.frame_start, result.byte_role};
    assign m_axis_tlast  = result.frame_end;

    // A byte held back by a stalled result register must stay put.
    `SHFP_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg), "held input byte changed or was lost")
    // Every consumed byte shows up as a result in the next cycle.
    `SHFP_ASSERT_NEXT(a_advance_result, advance,
        m_axis_tvalid && (m_axis_tdata[7:0] == $past(in_byte_reg)),
        "consumed byte did not reach the result register")
    // The frame end can only be marked on a CRC byte.
    `SHFP_ASSERT_NOW(a_end_on_crc, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser[2:0] == ROLE_CRC, "frame end on a byte that is not a CRC byte")
    // A frame start is a sync byte with the length not yet known.
    `SHFP_ASSERT_NOW(a_start_is_sync, m_axis_tvalid && m_axis_tuser[3],
        (m_axis_tuser[2:0] == ROLE_SYNC) && (m_axis_tdata[23:8] == 16'd0)
            && !m_axis_tlast,
        "frame start flag on an unexpected byte")

endmodule

// ===== hdl/shfp_parser.sv =====
// ----------------------------------------------------------------------------
// shfp_parser
// Frame state machine, CRC register and result register; one byte per step.
// ----------------------------------------------------------------------------
module shfp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  ignore_crc,
    input  logic [7:0]            rx_byte,
    output shfp_pkg::shfp_result_t result
);
    import shfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_SYNC3   = 3'd2,
        PH_HEADER  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [31:0]  crc_reg, crc_next;
    logic [4:0]   header_count_reg, header_count_next;
    logic [15:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]   length_low_reg, length_low_next;
    logic [15:0]  length_reg, length_next;
    shfp_result_t result_reg, result_next;

    logic [31:0]  crc_upd;
    logic [4:0]   header_count_inc;
    logic         do_hunt;

    always_comb begin
        crc_upd           = crc_byte(crc_reg, rx_byte);
        header_count_inc  = header_count_reg + 5'd1;
        phase_next        = phase_reg;
        crc_next          = crc_reg;
        header_count_next = header_count_reg;
        bytes_left_next   = bytes_left_reg;
        length_low_next   = length_low_reg;
        length_next       = length_reg;
        do_hunt           = 1'b0;

        result_next.byte_echo      = rx_byte;
        result_next.byte_role      = ROLE_DISCARD;
        result_next.frame_start    = 1'b0;
        result_next.frame_end      = 1'b0;
        result_next.crc_good       = 1'b0;
        result_next.payload_length = length_reg;

        unique case (phase_reg)
            PH_SYNC2, PH_SYNC3: begin
                if (rx_byte == ((phase_reg == PH_SYNC2) ? SYNC2 : SYNC3)) begin
                    crc_next              = crc_upd;
                    header_count_next     = header_count_inc;
                    phase_next            = (phase_reg == PH_SYNC2) ? PH_SYNC3 : PH_HEADER;
                    result_next.byte_role = ROLE_SYNC;
                end else begin
                    do_hunt = 1'b1;
                end
            end
            PH_HEADER: begin
                crc_next              = crc_upd;
                header_count_next     = header_count_inc;
                result_next.byte_role = ROLE_HEADER;
                if (header_count_reg == LEN_LO_OFS) begin
                    length_low_next = rx_byte;
                end else if (header_count_reg == LEN_HI_OFS) begin
                    length_next = {rx_byte, length_low_reg};
                end
                if (header_count_inc >= HEADER_BYTES) begin
                    if (length_next == 16'd0) begin
                        // Empty payload: the CRC bytes follow the header directly.
                        crc_next        = crc_upd ^ CRC_INIT;
                        bytes_left_next = CRC_BYTES;
                        phase_next      = PH_CRC;
                    end else begin
                        bytes_left_next = length_next;
                        phase_next      = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                result_next.byte_role = ROLE_PAYLOAD;
                if (bytes_left_reg <= 16'd1) begin
                    crc_next        = crc_upd ^ CRC_INIT;
                    bytes_left_next = CRC_BYTES;
                    phase_next      = PH_CRC;
                end else begin
                    crc_next        = crc_upd;
                    bytes_left_next = bytes_left_reg - 16'd1;
                end
            end
            PH_CRC: begin
                crc_next              = crc_upd;
                result_next.byte_role = ROLE_CRC;
                if (bytes_left_reg <= 16'd1) begin
                    bytes_left_next       = 16'd0;
                    result_next.frame_end = 1'b1;
                    result_next.crc_good  = (crc_upd == 32'd0) || ignore_crc;
                    phase_next            = PH_HUNT;
                end else begin
                    bytes_left_next = bytes_left_reg - 16'd1;
                end
            end
            default: begin
                do_hunt = 1'b1;
            end
        endcase

        if (do_hunt) begin
            if (rx_byte == SYNC1) begin
                crc_next                = CRC_AFTER_SYNC1;
                header_count_next       = 5'd1;
                length_low_next         = 8'd0;
                length_next             = 16'd0;
                bytes_left_next         = 16'd0;
                phase_next              = PH_SYNC2;
                result_next.byte_role   = ROLE_SYNC;
                result_next.frame_start = 1'b1;
            end else begin
                phase_next            = PH_HUNT;
                result_next.byte_role = ROLE_DISCARD;
            end
        end

        result_next.payload_length = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            crc_reg          <= CRC_INIT;
            header_count_reg <= 5'd0;
            bytes_left_reg   <= 16'd0;
            length_low_reg   <= 8'd0;
            length_reg       <= 16'd0;
        end else if (step) begin
            phase_reg        <= phase_next;
            crc_reg          <= crc_next;
            header_count_reg <= header_count_next;
            bytes_left_reg   <= bytes_left_next;
            length_low_reg   <= length_low_next;
            length_reg       <= length_next;
            result_reg       <= result_next;
        end
    end

    assign result = result_reg;

endmodule
